FILE: rtl/fractal_range_domain_match_core_defines.svh
// assertion helpers shared by the match core modules
`ifndef FRACTAL_RANGE_DOMAIN_MATCH_CORE_DEFINES_SVH
`define FRACTAL_RANGE_DOMAIN_MATCH_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FRDM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FRDM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/frdm_pkg.sv
package frdm_pkg;

    localparam int RANGE_W  = 8;
    localparam int DOMAIN_W = 12;
    localparam int COORD_W  = 16;
    localparam int ANGLE_W  = 2;
    localparam int FIT_W    = 24;
    localparam int ERR_W    = 32;

    // metadata of one closed candidate
    typedef struct packed {
        logic               search;
        logic [ANGLE_W-1:0] angle;
        logic               direction;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } cand_meta_t;

    localparam int META_W = $bits(cand_meta_t);

endpackage

FILE: rtl/frdm_fifo.sv
`include "fractal_range_domain_match_core_defines.svh"

module frdm_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    input  logic              pop,
    output logic [DATA_W-1:0] dout,
    output logic              full,
    output logic              empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `FRDM_ASSERT_NOW(a_fifo_no_overflow, push, !full, "candidate queue overflow")
    `FRDM_ASSERT_NOW(a_fifo_no_underflow, pop, !empty, "candidate queue underflow")
    `FRDM_ASSERT_NEXT(a_fifo_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not advance on push")

endmodule

FILE: rtl/frdm_front.sv
module frdm_front import frdm_pkg::*; #(
    parameter int MAX_PIX = 256,
    parameter int CNT_W   = $clog2(MAX_PIX + 1),
    parameter int SD_W    = CNT_W + 12,
    parameter int SR_W    = CNT_W + 8,
    parameter int SDD_W   = CNT_W + 24,
    parameter int SRR_W   = CNT_W + 16,
    parameter int SDR_W   = CNT_W + 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [RANGE_W-1:0]  range_pixel,
    input  logic [DOMAIN_W-1:0] domain_pixel,
    input  logic [COORD_W-1:0]  domain_x,
    input  logic [COORD_W-1:0]  domain_y,
    input  logic                direction,
    input  logic [ANGLE_W-1:0]  angle,
    input  logic                block_last,
    input  logic                search_last,
    input  logic                queue_full,
    output logic                push,
    output cand_meta_t          push_meta,
    output logic [CNT_W-1:0]    push_n,
    output logic [SD_W-1:0]     push_sd,
    output logic [SR_W-1:0]     push_sr,
    output logic [SDD_W-1:0]    push_sdd,
    output logic [SRR_W-1:0]    push_srr,
    output logic [SDR_W-1:0]    push_sdr
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SD_W-1:0]  sd_reg, sd_next;
    logic [SR_W-1:0]  sr_reg, sr_next;
    logic [SDD_W-1:0] sdd_reg, sdd_next;
    logic [SRR_W-1:0] srr_reg, srr_next;
    logic [SDR_W-1:0] sdr_reg, sdr_next;

    logic             accept;
    logic             room;
    logic             close;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign room     = (cnt_reg < CNT_W'(MAX_PIX));
    assign close    = block_last || search_last;
    assign push     = accept && close;

    // sums including the current word while the block has room
    always_comb
    begin
        push_n   = cnt_reg;
        push_sd  = sd_reg;
        push_sr  = sr_reg;
        push_sdd = sdd_reg;
        push_srr = srr_reg;
        push_sdr = sdr_reg;
        if (room)
        begin
            push_n   = cnt_reg + 1'b1;
            push_sd  = sd_reg + SD_W'(domain_pixel);
            push_sr  = sr_reg + SR_W'(range_pixel);
            push_sdd = sdd_reg + SDD_W'(domain_pixel * domain_pixel);
            push_srr = srr_reg + SRR_W'(range_pixel * range_pixel);
            push_sdr = sdr_reg + SDR_W'(domain_pixel * DOMAIN_W'(range_pixel));
        end
    end

    always_comb
    begin
        push_meta.x         = domain_x;
        push_meta.y         = domain_y;
        push_meta.direction = direction;
        push_meta.angle     = angle;
        push_meta.search    = search_last;
    end

    // accumulators clear when a candidate closes
    always_comb
    begin
        cnt_next = cnt_reg;
        sd_next  = sd_reg;
        sr_next  = sr_reg;
        sdd_next = sdd_reg;
        srr_next = srr_reg;
        sdr_next = sdr_reg;
        if (accept)
        begin
            if (close)
            begin
                cnt_next = '0;
                sd_next  = '0;
                sr_next  = '0;
                sdd_next = '0;
                srr_next = '0;
                sdr_next = '0;
            end
            else
            begin
                cnt_next = push_n;
                sd_next  = push_sd;
                sr_next  = push_sr;
                sdd_next = push_sdd;
                srr_next = push_srr;
                sdr_next = push_sdr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sd_reg  <= '0;
            sr_reg  <= '0;
            sdd_reg <= '0;
            srr_reg <= '0;
            sdr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sd_reg  <= sd_next;
            sr_reg  <= sr_next;
            sdd_reg <= sdd_next;
            srr_reg <= srr_next;
            sdr_reg <= sdr_next;
        end
    end

endmodule

FILE: rtl/frdm_div.sv
module frdm_div #(
    parameter int NUM_W = 100,
    parameter int DEN_W = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = num_reg;

    // one restoring step per cycle, quotient bits shift into the numerator
    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
            num_next = {num_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

FILE: rtl/frdm_back.sv
`include "fractal_range_domain_match_core_defines.svh"

module frdm_back import frdm_pkg::*; #(
    parameter int CNT_W = 9,
    parameter int SD_W  = CNT_W + 12,
    parameter int SR_W  = CNT_W + 8,
    parameter int SDD_W = CNT_W + 24,
    parameter int SRR_W = CNT_W + 16,
    parameter int SDR_W = CNT_W + 20,
    parameter int MW    = SD_W + 29,
    parameter int X_W   = 2 * MW
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [ERR_W-1:0]   cfg_wdata,
    input  logic               queue_empty,
    output logic               pop,
    input  cand_meta_t         pop_meta,
    input  logic [CNT_W-1:0]   pop_n,
    input  logic [SD_W-1:0]    pop_sd,
    input  logic [SR_W-1:0]    pop_sr,
    input  logic [SDD_W-1:0]   pop_sdd,
    input  logic [SRR_W-1:0]   pop_srr,
    input  logic [SDR_W-1:0]   pop_sdr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] best_x,
    output logic [COORD_W-1:0] best_y,
    output logic               best_direction,
    output logic [ANGLE_W-1:0] best_angle,
    output logic [FIT_W-1:0]   contrast,
    output logic [FIT_W-1:0]   brightness,
    output logic [ERR_W-1:0]   match_error,
    output logic               found,
    output logic               early_exit
);

    localparam logic [ERR_W-1:0] THRESH_RESET = 32'd128000;
    localparam logic [FIT_W-1:0] SAT_POS      = 24'h7FFFFF;
    localparam logic [FIT_W-1:0] SAT_NEG      = 24'h800000;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_ISSUE    = 5'b00010,
        ST_MUL_WAIT = 5'b00100,
        ST_DIV_WAIT = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    typedef enum logic [14:0] {
        STP_ND  = 15'b000000000000001,
        STP_DR  = 15'b000000000000010,
        STP_NDD = 15'b000000000000100,
        STP_DD  = 15'b000000000001000,
        STP_NRR = 15'b000000000010000,
        STP_RR  = 15'b000000000100000,
        STP_DS  = 15'b000000001000000,
        STP_SSD = 15'b000000010000000,
        STP_DO  = 15'b000000100000000,
        STP_SS  = 15'b000001000000000,
        STP_SB  = 15'b000010000000000,
        STP_SA  = 15'b000100000000000,
        STP_ON  = 15'b001000000000000,
        STP_QQ  = 15'b010000000000000,
        STP_DE  = 15'b100000000000000
    } step_t;

    function automatic logic [X_W-1:0] mag_x(input logic signed [X_W-1:0] v);
        mag_x = v[X_W-1] ? X_W'(-v) : X_W'(v);
    endfunction

    function automatic logic [FIT_W-1:0] mag_f(input logic [FIT_W-1:0] v);
        mag_f = v[FIT_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [FIT_W-1:0] sat_fit(input logic neg, input logic [X_W-1:0] m);
        if (neg)
        begin
            sat_fit = (m > X_W'(SAT_NEG)) ? SAT_NEG : FIT_W'(~m + 1'b1);
        end
        else
        begin
            sat_fit = (m > X_W'(SAT_POS)) ? SAT_POS : m[FIT_W-1:0];
        end
    endfunction

    state_t                state_reg, state_next;
    step_t                 step_reg, step_next;

    // control registers
    logic [ERR_W-1:0]      thr_reg;
    logic                  have_best_reg;
    logic                  search_done_reg;
    logic                  out_valid_reg;

    // latched candidate
    cand_meta_t            ent_meta_reg;
    logic [CNT_W-1:0]      ent_n_reg;
    logic [SD_W-1:0]       ent_sd_reg;
    logic [SR_W-1:0]       ent_sr_reg;
    logic [SDD_W-1:0]      ent_sdd_reg;
    logic [SRR_W-1:0]      ent_srr_reg;
    logic [SDR_W-1:0]      ent_sdr_reg;

    // fit datapath
    logic signed [X_W-1:0] a_reg;
    logic signed [X_W-1:0] b_reg;
    logic signed [X_W-1:0] c_reg;
    logic signed [X_W-1:0] onum_reg;
    logic signed [X_W-1:0] q_reg;
    logic [X_W-1:0]        x_reg;
    logic [FIT_W-1:0]      s_reg;
    logic [FIT_W-1:0]      o_reg;

    // kept candidate
    cand_meta_t            bst_meta_reg;
    logic [FIT_W-1:0]      bst_s_reg;
    logic [FIT_W-1:0]      bst_o_reg;
    logic [ERR_W-1:0]      bst_err_reg;

    // result register
    logic [COORD_W-1:0]    o_x_reg;
    logic [COORD_W-1:0]    o_y_reg;
    logic                  o_dir_reg;
    logic [ANGLE_W-1:0]    o_ang_reg;
    logic [FIT_W-1:0]      o_s_reg;
    logic [FIT_W-1:0]      o_o_reg;
    logic [ERR_W-1:0]      o_err_reg;
    logic                  o_found_reg;
    logic                  o_exit_reg;

    // shift-add multiplier
    logic [X_W-1:0]        mul_a_reg;
    logic [MW-1:0]         mul_b_reg;
    logic [X_W-1:0]        mul_acc_reg;

    logic                  use_div;
    logic [MW-1:0]         op_a;
    logic [MW-1:0]         op_b;
    logic [X_W-1:0]        div_num;
    logic [MW-1:0]         div_den;
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [X_W-1:0]        div_quo;

    logic                  retire;
    logic [X_W-1:0]        res;
    logic signed [X_W-1:0] res_s;
    logic signed [X_W-1:0] b_new;
    logic signed [X_W-1:0] c_new;
    logic signed [X_W-1:0] ssd;
    logic signed [X_W-1:0] on_s;
    logic [X_W-1:0]        t_sa;
    logic [ERR_W-1:0]      err_val;
    logic                  better;
    logic                  out_load;
    logic                  clear_search;

    assign pop         = (state_reg == ST_IDLE) && !queue_empty;
    assign retire      = ((state_reg == ST_MUL_WAIT) && (mul_b_reg == '0)) ||
                         ((state_reg == ST_DIV_WAIT) && div_done);
    assign res         = (state_reg == ST_DIV_WAIT) ? div_quo : mul_acc_reg;
    assign res_s       = $signed(res);
    assign b_new       = b_reg - res_s;
    assign c_new       = c_reg - res_s;
    assign ssd         = s_reg[FIT_W-1] ? -res_s : res_s;
    assign on_s        = o_reg[FIT_W-1] ? -res_s : res_s;
    assign t_sa        = res << 21;
    assign err_val     = (res[X_W-1:ERR_W] != '0) ? '1 : res[ERR_W-1:0];
    assign better      = !have_best_reg || (err_val < bst_err_reg);
    assign out_load    = (state_reg == ST_FINISH) && ent_meta_reg.search &&
                         (!out_valid_reg || out_ready);
    assign clear_search = out_load;
    assign div_start   = (state_reg == ST_ISSUE) && use_div;

    // operands of the current step
    always_comb
    begin
        use_div = 1'b0;
        op_a    = '0;
        op_b    = '0;
        div_num = '0;
        div_den = '0;
        unique case (step_reg)
            STP_ND:
            begin
                op_a = MW'(ent_n_reg);
                op_b = MW'(ent_sdr_reg);
            end
            STP_DR:
            begin
                op_a = MW'(ent_sd_reg);
                op_b = MW'(ent_sr_reg);
            end
            STP_NDD:
            begin
                op_a = MW'(ent_n_reg);
                op_b = MW'(ent_sdd_reg);
            end
            STP_DD:
            begin
                op_a = MW'(ent_sd_reg);
                op_b = MW'(ent_sd_reg);
            end
            STP_NRR:
            begin
                op_a = MW'(ent_n_reg);
                op_b = MW'(ent_srr_reg);
            end
            STP_RR:
            begin
                op_a = MW'(ent_sr_reg);
                op_b = MW'(ent_sr_reg);
            end
            STP_DS:
            begin
                use_div = 1'b1;
                div_num = (mag_x(a_reg) << 21) + X_W'(b_reg);
                div_den = MW'(X_W'(b_reg) << 1);
            end
            STP_SSD:
            begin
                op_a = MW'(mag_f(s_reg));
                op_b = MW'(ent_sd_reg);
            end
            STP_DO:
            begin
                use_div = 1'b1;
                div_num = (mag_x(onum_reg) << 1) + (X_W'(ent_n_reg) << 12);
                div_den = MW'(ent_n_reg) << 13;
            end
            STP_SS:
            begin
                op_a = MW'(mag_f(s_reg));
                op_b = MW'(mag_f(s_reg));
            end
            STP_SB:
            begin
                op_a = x_reg[MW-1:0];
                op_b = MW'(X_W'(b_reg));
            end
            STP_SA:
            begin
                op_a = MW'(mag_f(s_reg));
                op_b = MW'(mag_x(a_reg));
            end
            STP_ON:
            begin
                op_a = MW'(mag_f(o_reg));
                op_b = MW'(ent_n_reg);
            end
            STP_QQ:
            begin
                op_a = MW'(mag_x(q_reg));
                op_b = MW'(mag_x(q_reg));
            end
            STP_DE:
            begin
                use_div = 1'b1;
                div_num = x_reg >> 32;
                div_den = MW'(ent_n_reg);
            end
            default:
            begin
                use_div = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    step_next  = STP_ND;
                    state_next = search_done_reg ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = use_div ? ST_DIV_WAIT : ST_MUL_WAIT;
            end
            ST_MUL_WAIT, ST_DIV_WAIT:
            begin
                if (retire)
                begin
                    state_next = ST_ISSUE;
                    unique case (step_reg)
                        STP_ND:  step_next = STP_DR;
                        STP_DR:  step_next = STP_NDD;
                        STP_NDD: step_next = STP_DD;
                        STP_DD:
                        begin
                            step_next = STP_NRR;
                            if (b_new <= 0)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        STP_NRR: step_next = STP_RR;
                        STP_RR:  step_next = STP_DS;
                        STP_DS:  step_next = STP_SSD;
                        STP_SSD: step_next = STP_DO;
                        STP_DO:  step_next = STP_SS;
                        STP_SS:  step_next = STP_SB;
                        STP_SB:  step_next = STP_SA;
                        STP_SA:  step_next = STP_ON;
                        STP_ON:  step_next = STP_QQ;
                        STP_QQ:  step_next = STP_DE;
                        STP_DE:  state_next = ST_FINISH;
                        default: step_next = STP_ND;
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (!ent_meta_reg.search || out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= STP_ND;
            thr_reg         <= THRESH_RESET;
            have_best_reg   <= 1'b0;
            search_done_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (retire && (step_reg == STP_DE) && better)
            begin
                have_best_reg <= 1'b1;
                if (err_val < thr_reg)
                begin
                    search_done_reg <= 1'b1;
                end
            end
            if (clear_search)
            begin
                have_best_reg   <= 1'b0;
                search_done_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // multiplier, one partial product per cycle
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_ISSUE) && !use_div)
        begin
            mul_a_reg   <= X_W'(op_a);
            mul_b_reg   <= op_b;
            mul_acc_reg <= '0;
        end
        else if ((state_reg == ST_MUL_WAIT) && (mul_b_reg != '0))
        begin
            if (mul_b_reg[0])
            begin
                mul_acc_reg <= mul_acc_reg + mul_a_reg;
            end
            mul_a_reg <= mul_a_reg << 1;
            mul_b_reg <= mul_b_reg >> 1;
        end
    end

    // candidate latch and fit datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_meta_reg <= pop_meta;
            ent_n_reg    <= pop_n;
            ent_sd_reg   <= pop_sd;
            ent_sr_reg   <= pop_sr;
            ent_sdd_reg  <= pop_sdd;
            ent_srr_reg  <= pop_srr;
            ent_sdr_reg  <= pop_sdr;
        end
        if (retire)
        begin
            case (step_reg)
                STP_ND:  a_reg <= res_s;
                STP_DR:  a_reg <= a_reg - res_s;
                STP_NDD: b_reg <= res_s;
                STP_DD:  b_reg <= b_new;
                STP_NRR: c_reg <= res_s;
                STP_RR:  c_reg <= c_new[X_W-1] ? '0 : c_new;
                STP_DS:  s_reg <= sat_fit(a_reg[X_W-1], res);
                STP_SSD: onum_reg <= $signed(X_W'(ent_sr_reg) << 20) - ssd;
                STP_DO:  o_reg <= sat_fit(onum_reg[X_W-1], res);
                STP_SS:  x_reg <= res;
                STP_SB:  x_reg <= res + (X_W'(c_reg) << 40);
                STP_SA:
                begin
                    if (s_reg[FIT_W-1] == a_reg[X_W-1])
                    begin
                        x_reg <= (x_reg < t_sa) ? '0 : x_reg - t_sa;
                    end
                    else
                    begin
                        x_reg <= x_reg + t_sa;
                    end
                end
                STP_ON:  q_reg <= (on_s <<< 12) - onum_reg;
                STP_QQ:  x_reg <= x_reg + res;
                STP_DE:
                begin
                    if (better)
                    begin
                        bst_meta_reg <= ent_meta_reg;
                        bst_s_reg    <= s_reg;
                        bst_o_reg    <= o_reg;
                        bst_err_reg  <= err_val;
                    end
                end
                default:
                begin
                    x_reg <= x_reg;
                end
            endcase
        end
        if (out_load)
        begin
            o_x_reg     <= have_best_reg ? bst_meta_reg.x : '0;
            o_y_reg     <= have_best_reg ? bst_meta_reg.y : '0;
            o_dir_reg   <= have_best_reg ? bst_meta_reg.direction : 1'b0;
            o_ang_reg   <= have_best_reg ? bst_meta_reg.angle : '0;
            o_s_reg     <= have_best_reg ? bst_s_reg : '0;
            o_o_reg     <= have_best_reg ? bst_o_reg : '0;
            o_err_reg   <= have_best_reg ? bst_err_reg : '0;
            o_found_reg <= have_best_reg;
            o_exit_reg  <= search_done_reg;
        end
    end

    frdm_div #(
        .NUM_W (X_W),
        .DEN_W (MW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_valid      = out_valid_reg;
    assign best_x         = o_x_reg;
    assign best_y         = o_y_reg;
    assign best_direction = o_dir_reg;
    assign best_angle     = o_ang_reg;
    assign contrast       = o_s_reg;
    assign brightness     = o_o_reg;
    assign match_error    = o_err_reg;
    assign found          = o_found_reg;
    assign early_exit     = o_exit_reg;

    `FRDM_ASSERT_NOW(a_div_only_in_wait, div_busy, state_reg == ST_DIV_WAIT,
        "divider running outside its wait state")
    `FRDM_ASSERT_NOW(a_load_into_free_slot, out_load, !out_valid_reg || out_ready,
        "result overwrote an untaken word")
    `FRDM_ASSERT_NEXT(a_search_clears, out_load, !have_best_reg && !search_done_reg,
        "search state not cleared after result")

endmodule

FILE: rtl/fractal_range_domain_match_core.sv
// Best domain match for one range block. Pixel pairs enter one word per cycle
// and are summed in the front end; each closed candidate goes through a
// four-entry queue to the back end, which fits contrast and brightness and
// scores the candidate with a shift-add multiplier (one operand bit per cycle,
// twelve products) and a restoring divider (three quotients). A flat candidate
// stops after four products. A candidate that arrives after an early exit is
// dropped. Input stalls only while the queue is full. The single result word
// appears once the candidate that carries search_last has been scored or
// dropped.
module fractal_range_domain_match_core import frdm_pkg::*; #(
    parameter int MAX_BLOCK_PIXELS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // range_pixel[7:0], domain_pixel[19:8], domain_x[35:20], domain_y[51:36]
    input  logic [55:0]  s_axis_tdata,
    // direction[0], angle[2:1], block_last[3]
    input  logic [3:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // best_x[15:0], best_y[31:16], contrast[55:32], brightness[79:56],
    // match_error[111:80]
    output logic [111:0] m_axis_tdata,
    // best_direction[0], best_angle[2:1], found[3], early_exit[4]
    output logic [4:0]   m_axis_tuser
);

    localparam int CNT_W  = $clog2(MAX_BLOCK_PIXELS + 1);
    localparam int SD_W   = CNT_W + 12;
    localparam int SR_W   = CNT_W + 8;
    localparam int SDD_W  = CNT_W + 24;
    localparam int SRR_W  = CNT_W + 16;
    localparam int SDR_W  = CNT_W + 20;
    localparam int MW     = SD_W + 29;
    localparam int X_W    = 2 * MW;
    localparam int Q_DEPTH = 4;
    localparam int ENT_W  = META_W + CNT_W + SD_W + SR_W + SDD_W + SRR_W + SDR_W;

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    logic [ENT_W-1:0] q_din;
    logic [ENT_W-1:0] q_dout;

    cand_meta_t       f_meta;
    logic [CNT_W-1:0] f_n;
    logic [SD_W-1:0]  f_sd;
    logic [SR_W-1:0]  f_sr;
    logic [SDD_W-1:0] f_sdd;
    logic [SRR_W-1:0] f_srr;
    logic [SDR_W-1:0] f_sdr;

    cand_meta_t       b_meta;
    logic [CNT_W-1:0] b_n;
    logic [SD_W-1:0]  b_sd;
    logic [SR_W-1:0]  b_sr;
    logic [SDD_W-1:0] b_sdd;
    logic [SRR_W-1:0] b_srr;
    logic [SDR_W-1:0] b_sdr;

    logic [FIT_W-1:0] r_contrast;
    logic [FIT_W-1:0] r_brightness;
    logic [ERR_W-1:0] r_error;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic             r_dir;
    logic [ANGLE_W-1:0] r_angle;
    logic             r_found;
    logic             r_exit;

    frdm_front #(
        .MAX_PIX (MAX_BLOCK_PIXELS),
        .CNT_W   (CNT_W),
        .SD_W    (SD_W),
        .SR_W    (SR_W),
        .SDD_W   (SDD_W),
        .SRR_W   (SRR_W),
        .SDR_W   (SDR_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .range_pixel  (s_axis_tdata[7:0]),
        .domain_pixel (s_axis_tdata[19:8]),
        .domain_x     (s_axis_tdata[35:20]),
        .domain_y     (s_axis_tdata[51:36]),
        .direction    (s_axis_tuser[0]),
        .angle        (s_axis_tuser[2:1]),
        .block_last   (s_axis_tuser[3]),
        .search_last  (s_axis_tlast),
        .queue_full   (q_full),
        .push         (q_push),
        .push_meta    (f_meta),
        .push_n       (f_n),
        .push_sd      (f_sd),
        .push_sr      (f_sr),
        .push_sdd     (f_sdd),
        .push_srr     (f_srr),
        .push_sdr     (f_sdr)
    );

    // candidate queue packing
    assign q_din = {f_meta, f_n, f_sd, f_sr, f_sdd, f_srr, f_sdr};
    assign {b_meta, b_n, b_sd, b_sr, b_sdd, b_srr, b_sdr} = q_dout;

    frdm_fifo #(
        .DATA_W (ENT_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    frdm_back #(
        .CNT_W (CNT_W),
        .SD_W  (SD_W),
        .SR_W  (SR_W),
        .SDD_W (SDD_W),
        .SRR_W (SRR_W),
        .SDR_W (SDR_W),
        .MW    (MW),
        .X_W   (X_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .queue_empty    (q_empty),
        .pop            (q_pop),
        .pop_meta       (b_meta),
        .pop_n          (b_n),
        .pop_sd         (b_sd),
        .pop_sr         (b_sr),
        .pop_sdd        (b_sdd),
        .pop_srr        (b_srr),
        .pop_sdr        (b_sdr),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .best_x         (r_x),
        .best_y         (r_y),
        .best_direction (r_dir),
        .best_angle     (r_angle),
        .contrast       (r_contrast),
        .brightness     (r_brightness),
        .match_error    (r_error),
        .found          (r_found),
        .early_exit     (r_exit)
    );

    // result word packing
    assign m_axis_tdata = {r_error, r_brightness, r_contrast, r_y, r_x};
    assign m_axis_tuser = {r_exit, r_found, r_angle, r_dir};

endmodule

FILE: test/fractal_range_domain_match_core_tb.sv
module fractal_range_domain_match_core_tb;
    import frdm_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               dir;
        logic [ANGLE_W-1:0] ang;
        logic [FIT_W-1:0]   con;
        logic [FIT_W-1:0]   bri;
        logic [ERR_W-1:0]   err;
        logic               found;
        logic               early;
    } match_t;

    localparam int BLOCK_MAX     = 256;
    localparam int SETTLE_CYCLES = 4000;

    // pattern kinds for one candidate
    typedef enum int {K_NOISE, K_POS_FIT, K_FLAT, K_EXACT, K_NEG_FIT, K_EXTREME} pat_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // range_pixel, domain_pixel, domain_x, domain_y
    logic [55:0]  s_axis_tdata;
    // direction, angle, block_last
    logic [3:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // best_x, best_y, contrast, brightness, match_error
    logic [111:0] m_axis_tdata;
    // best_direction, best_angle, found, early_exit
    logic [4:0]   m_axis_tuser;

    fractal_range_domain_match_core #(.MAX_BLOCK_PIXELS(BLOCK_MAX)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // predictor state
    longint          acc_n, acc_d, acc_r, acc_dd, acc_rr, acc_dr;
    match_t          best_match;
    logic [ERR_W-1:0] best_err;
    bit              search_stopped, have_best;
    logic [31:0]     threshold;
    match_t          pending_matches[$];

    int send_idle, recv_idle, hold_left;
    int words_sent, matches_seen, mismatches, found_count, early_count;
    int flat_value;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("timeout with %0d matches pending", pending_matches.size());
        $display("status: fail");
        $finish;
    end

    // receiver ready, with random stalls and long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic signed [159:0] round_quot(input logic signed [159:0] num,
                                                       input logic signed [159:0] den);
        logic signed [159:0] m, q;
        m = (num < 0) ? -num : num;
        q = (2 * m + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [159:0] clip24(input logic signed [159:0] v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // least squares fit and squared error of the current candidate
    task automatic score_candidate(input logic [15:0] x, input logic [15:0] y,
                                   input logic dir, input logic [1:0] ang);
        logic signed [159:0] n, sd, sr, a, b, crr, s, o, e, q, t;
        logic [ERR_W-1:0] err;
        n = acc_n; sd = acc_d; sr = acc_r;
        a = n * acc_dr - sd * sr;
        b = n * acc_dd - sd * sd;
        crr = n * acc_rr - sr * sr;
        if (n <= 0 || b <= 0)
            return;
        if (crr < 0)
            crr = 0;
        s = clip24(round_quot(a * 1048576, b));
        o = clip24(round_quot(sr * 1048576 - s * sd, n * 4096));
        e = s * s * b + (crr <<< 40) - ((s * a) <<< 21);
        if (e < 0)
            e = 0;
        q = o * n * 4096 + s * sd - sr * 1048576;
        e = e + q * q;
        t = e >>> 32;
        if (t >= (n <<< 32))
            err = '1;
        else
            err = t / n;
        if (!have_best || err < best_err)
        begin
            best_match.x = x;
            best_match.y = y;
            best_match.dir = dir;
            best_match.ang = ang;
            best_match.con = s[23:0];
            best_match.bri = o[23:0];
            best_err = err;
            have_best = 1'b1;
            if (err < threshold)
                search_stopped = 1'b1;
        end
    endtask

    task automatic clear_search();
        best_match = '{default: '0};
        best_err = '1;
        search_stopped = 1'b0;
        have_best = 1'b0;
    endtask

    // advance the predictor by one accepted word
    task automatic predict_word(input logic [55:0] data, input logic [3:0] user,
                                input logic last);
        longint r, d;
        match_t res;
        r = data[7:0];
        d = data[19:8];
        if (acc_n < BLOCK_MAX)
        begin
            acc_n++;
            acc_d += d; acc_r += r;
            acc_dd += d * d; acc_rr += r * r; acc_dr += d * r;
        end
        if (user[3] || last)
        begin
            if (!search_stopped)
                score_candidate(data[35:20], data[51:36], user[0], user[2:1]);
            acc_n = 0; acc_d = 0; acc_r = 0; acc_dd = 0; acc_rr = 0; acc_dr = 0;
        end
        if (!last)
            return;
        res = best_match;
        res.err = have_best ? best_err : '0;
        res.found = have_best;
        res.early = search_stopped;
        pending_matches = {pending_matches, res};
        clear_search();
    endtask

    // result checker
    always @(posedge clk)
    begin
        match_t exp_m, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x = m_axis_tdata[15:0];
            got.y = m_axis_tdata[31:16];
            got.con = m_axis_tdata[55:32];
            got.bri = m_axis_tdata[79:56];
            got.err = m_axis_tdata[111:80];
            got.dir = m_axis_tuser[0];
            got.ang = m_axis_tuser[2:1];
            got.found = m_axis_tuser[3];
            got.early = m_axis_tuser[4];
            matches_seen++;
            if (pending_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected match word: %p", got);
            end
            else
            begin
                exp_m = pending_matches.pop_front();
                if (got !== exp_m)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_m, got);
                end
                found_count += exp_m.found;
                early_count += exp_m.early;
            end
        end
    end

    // offer one pixel pair, called and returning at a falling edge
    task automatic send_word(input logic [7:0] r, input logic [11:0] d, input bit blk,
                             input bit last);
        logic [55:0] data;
        logic [3:0]  user;
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        data = {4'b0, 16'($urandom), 16'($urandom), d, r};
        user = {blk, 2'($urandom), 1'($urandom)};
        s_axis_tdata <= data;
        s_axis_tuser <= user;
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_word(data, user, last);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_candidate(input int len, input pat_t kind, input bit last,
                                  input bit close_blk);
        logic [11:0] d;
        logic [7:0]  r;
        int v;
        for (int i = 0; i < len; i++)
        begin
            d = 12'($urandom);
            r = 8'($urandom);
            case (kind)
                K_POS_FIT:
                    r = 8'((d >> 5) + $urandom_range(0, 3));
                K_FLAT:
                begin
                    if (i == 0)
                        flat_value = $urandom_range(0, 4095);
                    d = 12'(flat_value);
                end
                K_EXACT:
                begin
                    d = {4'($urandom), 4'($urandom), 4'b0};
                    r = d[11:4];
                end
                K_NEG_FIT:
                begin
                    v = 255 - int'(d >> 4) + $urandom_range(0, 2);
                    r = (v > 255) ? 8'd255 : 8'(v);
                end
                K_EXTREME:
                begin
                    d = i[0] ? 12'hFFF : 12'h000;
                    r = i[0] ? 8'h00 : 8'hFF;
                end
                default: ;
            endcase
            send_word(r, d, (i == len - 1) && close_blk, (i == len - 1) && last);
        end
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() > 0)
            @(negedge clk);
    endtask

    // threshold write once the block has gone quiet
    task automatic set_threshold(input logic [31:0] v);
        stop_sending();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        threshold = v;
    endtask

    task automatic test_directed();
        // extremes and a negative fit, both with negative contrast
        send_candidate(4, K_EXTREME, 1'b1, 1'b1);
        send_candidate(4, K_NEG_FIT, 1'b1, 1'b1);
        // flat candidate only: nothing kept
        send_candidate(3, K_FLAT, 1'b1, 1'b1);
        // exact fit exits early, later candidate ignored
        send_candidate(4, K_EXACT, 1'b0, 1'b1);
        send_candidate(4, K_NOISE, 1'b1, 1'b1);
        // search ends without block end
        send_candidate(4, K_POS_FIT, 1'b1, 1'b0);
        // single pixel candidate is flat
        send_candidate(1, K_NOISE, 1'b1, 1'b1);
    endtask

    task automatic test_random(input int n_words);
        int target, ncand, len;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            ncand = $urandom_range(1, 5);
            for (int c = 0; c < ncand; c++)
            begin
                len = ($urandom_range(19) == 0) ? 1 : $urandom_range(2, 12);
                send_candidate(len, pat_t'($urandom_range(0, 5)), c == ncand - 1,
                               (c != ncand - 1) || $urandom_range(1));
            end
        end
    endtask

    task automatic test_long_blocks();
        send_candidate(BLOCK_MAX, K_POS_FIT, 1'b0, 1'b1);
        send_candidate(BLOCK_MAX + 40, K_NOISE, 1'b1, 1'b1);
    endtask

    // receiver holds off while the sender keeps going
    task automatic test_backpressure();
        hold_left = 20000;
        for (int k = 0; k < 12; k++)
            send_candidate($urandom_range(2, 6), pat_t'($urandom_range(0, 5)), 1'b1, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        hold_left = 0;
        send_idle = 11;
        recv_idle = 84;
        threshold = 128000;
        acc_n = 0; acc_d = 0; acc_r = 0; acc_dd = 0; acc_rr = 0; acc_dr = 0;
        clear_search();
        words_sent = 0; matches_seen = 0; mismatches = 0;
        found_count = 0; early_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        set_threshold(32'd0);
        test_random(150);
        send_idle = 84;
        recv_idle = 11;
        set_threshold(32'hFFFF_FFFF);
        test_random(100);
        set_threshold($urandom);
        test_long_blocks();
        test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        set_threshold(32'd128000);
        test_random(150);

        stop_sending();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("sent %0d pixel words, checked %0d match words", words_sent, matches_seen);
        $display("%0d searches found a candidate, %0d stopped early, %0d mismatches",
                 found_count, early_count, mismatches);
        if (mismatches == 0 && pending_matches.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/frdm_pkg.sv
rtl/frdm_fifo.sv
rtl/frdm_front.sv
rtl/frdm_div.sv
rtl/frdm_back.sv
rtl/fractal_range_domain_match_core.sv
test/fractal_range_domain_match_core_tb.sv
